/* rtl/pe_pkg.sv */
`timescale 1ns / 1ps

package pe_pkg;

    // Field widths
    localparam int CP_W      = 21;
    localparam int CHAR_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int MAX_BYTES = 4;
    localparam int MAX_CHARS = 3 * MAX_BYTES;
    localparam int IDX_W     = $clog2(MAX_CHARS);
    localparam int NB_W      = $clog2(MAX_BYTES);

    // ASCII characters
    localparam logic [CHAR_W-1:0] CH_PCT   = 7'h25;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_USCR  = 7'h5F;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;
    localparam logic [CHAR_W-1:0] CH_0     = 7'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 7'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 7'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 7'h7A;
    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;

    // Code point range limits
    localparam logic [CP_W-1:0] CP_ASCII_END = 21'h00080;
    localparam logic [CP_W-1:0] CP_2B_END    = 21'h00800;
    localparam logic [CP_W-1:0] CP_3B_END    = 21'h10000;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h0D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h0DFFF;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

    // After classification
    typedef struct packed {
        logic              esc;
        logic              bad;
        logic [CHAR_W-1:0] ch;
        logic [CP_W-1:0]   cp;
    } t_s1;

    // After UTF-8 encoding
    typedef struct packed {
        logic                             esc;
        logic                             bad;
        logic [CHAR_W-1:0]                ch;
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [NB_W-1:0]                  nb_m1;
    } t_s2;

    // A complete run of characters for one code point
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [IDX_W-1:0]                 last_idx;
        logic                             bad;
    } t_run;

    // Upper-case hex digit of a nibble.
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_0 + {3'b000, v};
        end else begin
            return CH_UA + {3'b000, v} - 7'd10;
        end
    endfunction

    // Letters, digits and the four unreserved marks.
    function automatic logic is_unreserved(input logic [CP_W-1:0] cp);
        logic [CHAR_W-1:0] c;
        c = cp[CHAR_W-1:0];
        if (cp >= CP_ASCII_END) begin
            return 1'b0;
        end
        return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ)
            || (c >= CH_LA && c <= CH_LZ) || c == CH_DASH || c == CH_USCR
            || c == CH_DOT || c == CH_TILDE;
    endfunction

endpackage

/* rtl/pe_cp_if.sv */
`timescale 1ns / 1ps

interface pe_cp_if;
    import pe_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

/* rtl/pe_char_if.sv */
`timescale 1ns / 1ps

interface pe_char_if;
    import pe_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last_char;
    logic              bad_code_point;

    modport source (output valid, output out_char, output last_char, output bad_code_point,
                    input ready);
    modport sink   (input valid, input out_char, input last_char, input bad_code_point,
                    output ready);
endinterface

/* rtl/pe_class.sv */
`timescale 1ns / 1ps

module pe_class (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_space_as_plus,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [pe_pkg::CP_W-1:0] i_cp,
    output logic                    o_valid,
    input  logic                    i_ready,
    output pe_pkg::t_s1             o_data
);
    import pe_pkg::*;

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Decide whether the code point is a single character, an error or escaped.
    always_comb begin
        n_data.cp  = i_cp;
        n_data.esc = 1'b0;
        n_data.bad = 1'b0;
        n_data.ch  = CH_NUL;
        priority if (i_space_as_plus && i_cp == {14'd0, CH_SPACE}) begin
            n_data.ch = CH_PLUS;
        end else if (is_unreserved(i_cp)) begin
            n_data.ch = i_cp[CHAR_W-1:0];
        end else if ((i_cp >= CP_SURR_LO && i_cp <= CP_SURR_HI) || i_cp > CP_MAX) begin
            n_data.bad = 1'b1;
        end else begin
            n_data.esc = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

/* rtl/pe_utf8.sv */
`timescale 1ns / 1ps

module pe_utf8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  pe_pkg::t_s1 i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output pe_pkg::t_s2 o_data
);
    import pe_pkg::*;

    logic            r_valid;
    t_s2             r_data;
    t_s2             n_data;
    logic [CP_W-1:0] cp;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign cp      = i_data.cp;

    // UTF-8 byte sequence, lead byte first.
    always_comb begin
        n_data.esc   = i_data.esc;
        n_data.bad   = i_data.bad;
        n_data.ch    = i_data.ch;
        n_data.bytes = '0;
        n_data.nb_m1 = '0;
        priority if (cp < CP_ASCII_END) begin
            n_data.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp < CP_2B_END) begin
            n_data.bytes[0] = {3'b110, cp[10:6]};
            n_data.bytes[1] = {2'b10, cp[5:0]};
            n_data.nb_m1    = 2'd1;
        end else if (cp < CP_3B_END) begin
            n_data.bytes[0] = {4'b1110, cp[15:12]};
            n_data.bytes[1] = {2'b10, cp[11:6]};
            n_data.bytes[2] = {2'b10, cp[5:0]};
            n_data.nb_m1    = 2'd2;
        end else begin
            n_data.bytes[0] = {5'b11110, cp[20:18]};
            n_data.bytes[1] = {2'b10, cp[17:12]};
            n_data.bytes[2] = {2'b10, cp[11:6]};
            n_data.bytes[3] = {2'b10, cp[5:0]};
            n_data.nb_m1    = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

/* rtl/pe_hex.sv */
`timescale 1ns / 1ps

module pe_hex (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  pe_pkg::t_s2  i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output pe_pkg::t_run o_data
);
    import pe_pkg::*;

    logic             r_valid;
    t_run             r_data;
    t_run             n_data;
    logic [IDX_W-1:0] nb_ext;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign nb_ext  = {{(IDX_W-NB_W){1'b0}}, i_data.nb_m1};

    // If escaped, each byte becomes % and two hex digits.
    always_comb begin
        n_data.bad      = i_data.bad;
        n_data.chars    = '0;
        n_data.last_idx = '0;
        if (i_data.esc) begin
            for (int i = 0; i < MAX_BYTES; i++) begin
                n_data.chars[3*i]     = CH_PCT;
                n_data.chars[3*i + 1] = hex_char(i_data.bytes[i][7:4]);
                n_data.chars[3*i + 2] = hex_char(i_data.bytes[i][3:0]);
            end
            n_data.last_idx = (nb_ext << 1) + nb_ext + IDX_W'(2);
        end else begin
            n_data.chars[0] = i_data.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

/* rtl/pe_ser.sv */
`timescale 1ns / 1ps

module pe_ser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  pe_pkg::t_run              i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [pe_pkg::CHAR_W-1:0] o_char,
    output logic                      o_last,
    output logic                      o_bad
);
    import pe_pkg::*;

    logic                             r_valid;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] r_chars;
    logic [IDX_W-1:0]                 r_left;
    logic                             r_bad;
    logic                             n_valid;
    logic [MAX_CHARS-1:0][CHAR_W-1:0] n_chars;
    logic [IDX_W-1:0]                 n_left;
    logic                             n_bad;
    logic                             take;
    logic                             beat;

    // A new run may load while the last character of the current one leaves.
    assign o_last  = (r_left == '0);
    assign o_ready = !r_valid || (i_ready && o_last);
    assign take    = i_valid && o_ready;
    assign beat    = r_valid && i_ready;
    assign o_valid = r_valid;
    assign o_char  = r_chars[0];
    assign o_bad   = r_bad;

    // Shift the run down one character per output beat.
    always_comb begin
        n_valid = r_valid;
        n_chars = r_chars;
        n_left  = r_left;
        n_bad   = r_bad;
        priority if (take) begin
            n_valid = 1'b1;
            n_chars = i_data.chars;
            n_left  = i_data.last_idx;
            n_bad   = i_data.bad;
        end else if (beat) begin
            if (o_last) begin
                n_valid = 1'b0;
            end else begin
                n_chars = {CHAR_W'(0), r_chars[MAX_CHARS-1:1]};
                n_left  = r_left - IDX_W'(1);
            end
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chars <= n_chars;
        r_left  <= n_left;
        r_bad   <= n_bad;
    end
endmodule

/* rtl/percent_encode_utf8_unit.sv */
// The first character of a code point is presented after the classification, UTF-8, hex and
// serialiser registers. Throughput: one code point per cycle when it yields one character and the
// output is ready; an escaped code point of n UTF-8 bytes yields 3n characters (3 to 12).
// The serialiser, which sends one character per beat, sets the sustained rate.
// Reset is synchronous and active low: all stages empty, space_as_plus set to 1.
`timescale 1ns / 1ps

module percent_encode_utf8_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    pe_cp_if.sink     i_cp,
    pe_char_if.source o_char
);
    import pe_pkg::*;

    logic r_space_as_plus;
    logic s1_valid;
    logic s1_ready;
    t_s1  s1_data;
    logic s2_valid;
    logic s2_ready;
    t_s2  s2_data;
    logic s3_valid;
    logic s3_ready;
    t_run s3_data;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_as_plus <= 1'b1;
        end else if (i_cfg_we) begin
            r_space_as_plus <= i_cfg_wdata;
        end
    end

    // Classification stage.
    pe_class u_class (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_space_as_plus (r_space_as_plus),
        .i_valid         (i_cp.valid),
        .o_ready         (i_cp.ready),
        .i_cp            (i_cp.code_point),
        .o_valid         (s1_valid),
        .i_ready         (s1_ready),
        .o_data          (s1_data)
    );

    // UTF-8 encoding stage.
    pe_utf8 u_utf8 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    // Hex expansion stage.
    pe_hex u_hex (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    // Output serialiser.
    pe_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_data  (s3_data),
        .o_valid (o_char.valid),
        .i_ready (o_char.ready),
        .o_char  (o_char.out_char),
        .o_last  (o_char.last_char),
        .o_bad   (o_char.bad_code_point)
    );

    // An error result is a lone character of value zero.
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char.valid && o_char.bad_code_point |-> o_char.last_char && o_char.out_char == CH_NUL)
        else $error("error beat is not a lone zero character");

    // A run that has not ended keeps the output valid on the next cycle.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char.valid && o_char.ready && !o_char.last_char |=> o_char.valid)
        else $error("run of characters broken off");

    // A configuration write takes effect on the next cycle.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_space_as_plus == $past(i_cfg_wdata))
        else $error("space_as_plus not updated");
endmodule
